### hw/rtl/cumulative_ack_window_tracker_assert.svh
// ----------------------------------------------------------------------------
// Ack tracker assertion macros
// Property wrappers used by the top level checks.
// ----------------------------------------------------------------------------
`ifndef CUMULATIVE_ACK_WINDOW_TRACKER_ASSERT_SVH
`define CUMULATIVE_ACK_WINDOW_TRACKER_ASSERT_SVH

// same-cycle implication
`define CAWT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CAWT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/cawt_pkg.sv
// ----------------------------------------------------------------------------
// Ack tracker package
// Shared types, constants and helpers for the cumulative ack tracker.
// ----------------------------------------------------------------------------
package cawt_pkg;

  localparam int WORD_BITS  = 8;
  localparam int OFF_BITS   = 3;
  localparam int COUNT_BITS = 4;

  localparam logic [1:0] OUT_IN_ORDER = 2'd0;
  localparam logic [1:0] OUT_HELD     = 2'd1;
  localparam logic [1:0] OUT_STALE    = 2'd2;

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic [WORD_BITS-1:0]  mask;
    logic                  at_end;
  } run_t;

  function automatic logic [COUNT_BITS-1:0] trailing_ones(input logic [WORD_BITS-1:0] w);
    logic [COUNT_BITS-1:0] n;
    logic                  hit;
    n   = '0;
    hit = 1'b0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (!hit && w[i]) begin
        n = n + COUNT_BITS'(1);
      end else begin
        hit = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

### hw/rtl/cawt_bitmap_ram.sv
// ----------------------------------------------------------------------------
// Ack tracker bitmap RAM
// Pending-ack bitmap, one write and one registered read port.
// ----------------------------------------------------------------------------
module cawt_bitmap_ram #(
  parameter int ADDR_BITS = 13
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [ADDR_BITS-1:0]           wr_addr,
  input  logic [cawt_pkg::WORD_BITS-1:0] wr_data,
  input  logic                           rd_en,
  input  logic [ADDR_BITS-1:0]           rd_addr,
  output logic [cawt_pkg::WORD_BITS-1:0] rd_data
);

  logic [cawt_pkg::WORD_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/cawt_run_unit.sv
// ----------------------------------------------------------------------------
// Ack tracker run unit
// Measures the run of pending bits from an offset within one bitmap word.
// ----------------------------------------------------------------------------
module cawt_run_unit (
  input  logic [cawt_pkg::WORD_BITS-1:0] word,
  input  logic [cawt_pkg::OFF_BITS-1:0]  off,
  input  logic                           force_first,
  output cawt_pkg::run_t                 run
);

  logic [cawt_pkg::WORD_BITS-1:0]  w;
  logic [cawt_pkg::WORD_BITS-1:0]  shifted;
  logic [cawt_pkg::COUNT_BITS-1:0] n;
  logic [cawt_pkg::WORD_BITS:0]    ones;
  logic [cawt_pkg::COUNT_BITS:0]   span;

  always_comb begin
    w = word;
    if (force_first) begin
      w = word | (cawt_pkg::WORD_BITS'(1) << off);
    end
    shifted    = w >> off;
    n          = cawt_pkg::trailing_ones(shifted);
    ones       = ((cawt_pkg::WORD_BITS+1)'(1) << n) - (cawt_pkg::WORD_BITS+1)'(1);
    span       = (cawt_pkg::COUNT_BITS+1)'(off) + (cawt_pkg::COUNT_BITS+1)'(n);
    run.count  = n;
    run.mask   = ones[cawt_pkg::WORD_BITS-1:0] << off;
    run.at_end = (span == (cawt_pkg::COUNT_BITS+1)'(cawt_pkg::WORD_BITS));
  end

endmodule

### hw/rtl/cumulative_ack_window_tracker.sv
// Timing: a stale ack is answered in the next cycle; a held ack passes through the read
// and evaluate states; an in-order ack does the same and repeats them for each further
// bitmap word, read whenever the run reaches a word end (8 IDs/word). One transaction
// at a time; the next start is taken at the edge that ends the result cycle.
// Reset: synchronous; next expected ID returns to 1, then a clearing pass writes
// every bitmap word with busy high; the receiver cannot stall.
// ----------------------------------------------------------------------------
// Cumulative ack window tracker
// Tracks the cumulative ack point and a bitmap of out-of-order acks.
// ----------------------------------------------------------------------------
module cumulative_ack_window_tracker #(
  parameter int ID_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] ack_id,
  output logic        done,
  output logic [15:0] next_expected,
  output logic [16:0] advanced_by,
  output logic [1:0]  outcome
);

  localparam int ADDR_BITS = ID_BITS - cawt_pkg::OFF_BITS;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_EVAL  = 2'd3;

  logic [1:0]               state;
  logic [ID_BITS-1:0]       ne;
  logic [ID_BITS-1:0]       id;
  logic [ADDR_BITS-1:0]     row;
  logic                     in_order;
  logic                     first;
  logic [ID_BITS:0]         moved;
  logic [ID_BITS-1:0]       res_ne;
  logic [ID_BITS:0]         res_moved;

  logic [ID_BITS+15:0]      ack_ext;
  logic [ID_BITS-1:0]       ack_low;
  logic [ID_BITS-1:0]       ack_gap;
  logic [ID_BITS+15:0]      ne_ext;
  logic [ID_BITS+16:0]      moved_ext;

  logic                           wr_en;
  logic [cawt_pkg::WORD_BITS-1:0] wr_data;
  logic [cawt_pkg::WORD_BITS-1:0] rd_data;
  logic [cawt_pkg::OFF_BITS-1:0]  off;
  cawt_pkg::run_t                 run;
  logic [ID_BITS-1:0]             ne_sum;
  logic [ID_BITS:0]               moved_sum;
  logic                           res_in_order;

  assign ack_ext   = {{ID_BITS{1'b0}}, ack_id};
  assign ack_low   = ack_ext[ID_BITS-1:0];
  assign ack_gap   = ack_low - ne;
  assign ne_ext    = {16'b0, res_ne};
  assign moved_ext = {16'b0, res_moved};

  assign busy          = (state != S_IDLE);
  assign next_expected = ne_ext[15:0];
  assign advanced_by   = moved_ext[16:0];

  assign off       = in_order ? ne[cawt_pkg::OFF_BITS-1:0] : id[cawt_pkg::OFF_BITS-1:0];
  assign ne_sum    = ne + ID_BITS'(run.count);
  assign moved_sum = moved + (ID_BITS+1)'(run.count);

  assign res_in_order = (outcome == cawt_pkg::OUT_IN_ORDER);

  always_comb begin
    wr_en   = (state == S_CLEAR) || (state == S_EVAL);
    wr_data = '0;
    if (state == S_EVAL) begin
      if (in_order) begin
        wr_data = rd_data & ~run.mask;
      end else begin
        wr_data = rd_data | (cawt_pkg::WORD_BITS'(1) << id[cawt_pkg::OFF_BITS-1:0]);
      end
    end
  end

  cawt_bitmap_ram #(
    .ADDR_BITS(ADDR_BITS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(row),
    .wr_data(wr_data),
    .rd_en  (state == S_READ),
    .rd_addr(row),
    .rd_data(rd_data)
  );

  cawt_run_unit u_run (
    .word       (rd_data),
    .off        (off),
    .force_first(first),
    .run        (run)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      row   <= '0;
      ne    <= ID_BITS'(1);
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          row <= row + ADDR_BITS'(1);
          if (&row) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            id  <= ack_low;
            row <= ack_low[ID_BITS-1:cawt_pkg::OFF_BITS];
            if (ack_gap == '0) begin
              in_order <= 1'b1;
              first    <= 1'b1;
              moved    <= '0;
              state    <= S_READ;
            end else if (!ack_gap[ID_BITS-1]) begin
              in_order <= 1'b0;
              first    <= 1'b0;
              state    <= S_READ;
            end else begin
              done      <= 1'b1;
              outcome   <= cawt_pkg::OUT_STALE;
              res_ne    <= ne;
              res_moved <= '0;
            end
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (in_order) begin
            ne    <= ne_sum;
            moved <= moved_sum;
            first <= 1'b0;
            if (run.at_end && !moved_sum[ID_BITS]) begin
              row   <= ne_sum[ID_BITS-1:cawt_pkg::OFF_BITS];
              state <= S_READ;
            end else begin
              done      <= 1'b1;
              outcome   <= cawt_pkg::OUT_IN_ORDER;
              res_ne    <= ne_sum;
              res_moved <= moved_sum;
              state     <= S_IDLE;
            end
          end else begin
            done      <= 1'b1;
            outcome   <= cawt_pkg::OUT_HELD;
            res_ne    <= ne;
            res_moved <= '0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "cumulative_ack_window_tracker_assert.svh"

  `CAWT_ASSERT_NOW(a_held_no_move, done && !res_in_order, advanced_by == '0, "stray advance")
  `CAWT_ASSERT_NOW(a_in_order_moves, done && res_in_order, advanced_by != '0, "zero advance")
  `CAWT_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "transaction dropped")
  `CAWT_ASSERT_NOW(a_done_when_idle, done, !busy, "result strobe while still busy")

endmodule
